@@ rtl/core/lsbx_pkg.sv @@
// Package for the LSB steganography extractor.
// Holds phase and result codes, field widths and the result struct.
// No dependencies.
package lsbx_pkg;

  localparam int PIXEL_W    = 24;
  localparam int VALUE_W    = 32;
  localparam int NAME_LEN_W = 7;
  localparam int NAME_MAX   = 100;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_SIZE = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NAME_BYTE = 3'd0,
    KIND_NAME_END  = 3'd1,
    KIND_SIZE      = 3'd2,
    KIND_DATA      = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_t;

  localparam logic [VALUE_W-1:0] ERR_SIZE_TOO_BIG  = 32'd0;
  localparam logic [VALUE_W-1:0] ERR_NAME_TOO_LONG = 32'd1;

  localparam logic REG_PIXEL_COUNT = 1'b0;

  typedef struct packed {
    logic               has;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

endpackage

@@ rtl/core/lsbx_core.sv @@
// Frame state and per-pixel decode step of the LSB extractor.
// Depends on lsbx_pkg.
module lsbx_core
  import lsbx_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_MAX
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic               first_pixel,
  input  logic [23:0]        pixel_count,
  output result_t            result
);

  phase_t                phase, phase_next;
  logic [1:0]            channel_turn, channel_turn_next;
  logic [2:0]            bit_count, bit_count_next;
  logic [7:0]            byte_shift, byte_shift_next;
  logic [31:0]           size_shift, size_shift_next;
  logic [5:0]            size_bits, size_bits_next;
  logic [31:0]           bytes_left, bytes_left_next;
  logic [NAME_LEN_W-1:0] name_length, name_length_next;

  always_comb begin
    logic       hbit;
    logic [7:0] nb;
    logic [31:0] ns;
    logic [31:0] left_dec;

    // restart the frame before this pixel is used
    if (first_pixel) begin
      phase_next        = PH_NAME;
      channel_turn_next = 2'd0;
      bit_count_next    = 3'd0;
      byte_shift_next   = 8'd0;
      size_shift_next   = 32'd0;
      size_bits_next    = 6'd0;
      bytes_left_next   = 32'd0;
      name_length_next  = '0;
    end else begin
      phase_next        = phase;
      channel_turn_next = channel_turn;
      bit_count_next    = bit_count;
      byte_shift_next   = byte_shift;
      size_shift_next   = size_shift;
      size_bits_next    = size_bits;
      bytes_left_next   = bytes_left;
      name_length_next  = name_length;
    end

    result       = '0;
    result.kind  = KIND_NAME_BYTE;

    unique case (channel_turn_next)
      2'd0:    hbit = pixel[16];
      2'd1:    hbit = pixel[8];
      default: hbit = pixel[0];
    endcase
    nb       = {byte_shift_next[6:0], hbit};
    ns       = {size_shift_next[30:0], hbit};
    left_dec = bytes_left_next - 32'd1;

    if (phase_next != PH_DONE) begin
      channel_turn_next = (channel_turn_next >= 2'd2) ? 2'd0 : channel_turn_next + 2'd1;
      if (phase_next == PH_SIZE) begin
        size_shift_next = ns;
        size_bits_next  = size_bits_next + 6'd1;
        if (size_bits_next == 6'd32) begin
          result.has = 1'b1;
          if (ns > {11'd0, pixel_count[23:3]}) begin
            phase_next   = PH_DONE;
            result.kind  = KIND_ERROR;
            result.value = ERR_SIZE_TOO_BIG;
            result.last  = 1'b1;
          end else begin
            bytes_left_next = ns;
            bit_count_next  = 3'd0;
            byte_shift_next = 8'd0;
            result.kind     = KIND_SIZE;
            result.value    = ns;
            if (ns == 32'd0) begin
              phase_next  = PH_DONE;
              result.last = 1'b1;
            end else begin
              phase_next  = PH_DATA;
            end
          end
        end
      end else begin
        byte_shift_next = nb;
        if (bit_count_next != 3'd7) begin
          bit_count_next = bit_count_next + 3'd1;
        end else begin
          bit_count_next = 3'd0;
          result.has     = 1'b1;
          if (phase_next == PH_NAME) begin
            if (nb == 8'd0) begin
              phase_next      = PH_SIZE;
              size_shift_next = 32'd0;
              size_bits_next  = 6'd0;
              byte_shift_next = 8'd0;
              result.kind     = KIND_NAME_END;
              result.value    = {{(VALUE_W-NAME_LEN_W){1'b0}}, name_length_next};
            end else if (name_length_next >= NAME_LEN_W'(NAME_LIMIT)) begin
              phase_next   = PH_DONE;
              result.kind  = KIND_ERROR;
              result.value = ERR_NAME_TOO_LONG;
              result.last  = 1'b1;
            end else begin
              name_length_next = name_length_next + NAME_LEN_W'(1);
              result.value     = {24'd0, nb};
            end
          end else begin
            bytes_left_next = left_dec;
            result.kind     = KIND_DATA;
            result.value    = {24'd0, nb};
            if (left_dec == 32'd0) begin
              phase_next  = PH_DONE;
              result.last = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NAME;
      channel_turn <= 2'd0;
      bit_count    <= 3'd0;
      byte_shift   <= 8'd0;
      size_shift   <= 32'd0;
      size_bits    <= 6'd0;
      bytes_left   <= 32'd0;
      name_length  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      channel_turn <= channel_turn_next;
      bit_count    <= bit_count_next;
      byte_shift   <= byte_shift_next;
      size_shift   <= size_shift_next;
      size_bits    <= size_bits_next;
      bytes_left   <= bytes_left_next;
      name_length  <= name_length_next;
    end
  end

endmodule

@@ rtl/core/lsb_stego_extractor_top.sv @@
// A request accepted into the input register is decoded into the result register.
// Throughput: one pixel per cycle; the input register and the result register
// each advance whenever the stage after them is empty or drained that cycle.
// The frame state lives in lsbx_core and updates once per pixel.
// Reset (rst, synchronous, active high) clears pixel_count, the frame state
// to the name phase at red, and both stage valids.
module lsb_stego_extractor_top
  import lsbx_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_MAX
)
(
  input  logic               clk,
  input  logic               rst,
  // pixel channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic               first_pixel,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [VALUE_W-1:0] value,
  output logic               last,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [23:0]        pixel_count;
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic               s1_first;
  logic               s1_fire;
  result_t            step_result;
  kind_t              out_kind;

  // APB: pready is tied high; byte address 4*i holds register i
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PIXEL_COUNT) ? {8'd0, pixel_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= 24'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_COUNT) begin
      pixel_count <= pwdata[23:0];
    end
  end

  // advance the input stage when the result register can take what it makes
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // hold the accepted request until it is decoded
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pixel <= pixel;
      s1_first <= first_pixel;
    end
  end

  lsbx_core #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_fire),
    .pixel       (s1_pixel),
    .first_pixel (s1_first),
    .pixel_count (pixel_count),
    .result      (step_result)
  );

  // result register: load a new result, drop one that was taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && step_result.has) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_result.has) begin
      out_kind <= step_result.kind;
      value    <= step_result.value;
      last     <= step_result.last;
    end
  end

  assign kind = out_kind;

endmodule

@@ rtl/core/lsbx_checker.sv @@
// Port-level checks for the LSB extractor, bound to the top level.
// Depends on lsbx_pkg and lsb_stego_extractor_top.
module lsbx_checker
  import lsbx_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input logic [2:0]   kind,
  input logic [31:0]  value,
  input logic         last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value) && $stable(last))
    else $error("result dropped or changed while stalled");

  a_name_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NAME_BYTE || kind == KIND_NAME_END) |-> !last)
    else $error("name result marked last");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> last && (value == ERR_SIZE_TOO_BIG ||
      value == ERR_NAME_TOO_LONG))
    else $error("error result malformed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lsb_stego_extractor_top lsbx_checker u_lsbx_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .value     (value),
  .last      (last)
);
